// ===== rtl/core/refid_pkg.sv =====
package refid_pkg;

  // Default sizing of the identifier space and the reference counts
  localparam int MAX_IDS_DEF    = 16384;
  localparam int COUNT_BITS_DEF = 16;

  // Fixed field widths of the request and response transfers
  localparam int MODE_W  = 2;
  localparam int TID_W   = 16;
  localparam int ID_W    = 14;
  localparam int STAT_W  = 2;
  localparam int NCNT_W  = 16;
  localparam int CFG_W   = 14;
  localparam int APB_DW  = 32;
  localparam int APB_AW  = 3;

  // Request modes
  localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ADD   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DROP  = 2'd2;

  // Response status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;
  localparam logic [STAT_W-1:0] STAT_COUNT = 2'd3;

  // Register word index of first_fresh_id
  localparam logic REG_FIRST_FRESH = 1'b0;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [TID_W-1:0]  target_id;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0]   result_id;
    logic [STAT_W-1:0] status;
    logic              released;
    logic [NCNT_W-1:0] new_count;
  } rsp_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic commit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
  } stat_t;

endpackage

// ===== rtl/core/refid_ram.sv =====
module refid_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/refid_ctrl.sv =====
module refid_ctrl
  import refid_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  req_valid,
  output logic  req_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;

  // Hold the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state: accept a request, then commit from ST_EXEC once the output slot is free
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    req_ready  = 1'b0;
    cmd.accept = 1'b0;
    cmd.commit = 1'b0;
    case (state)
      ST_IDLE: begin
        req_ready  = 1'b1;
        cmd.accept = req_valid;
      end
      ST_EXEC: begin
        cmd.commit = stat.out_free;
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/core/refid_dp.sv =====
module refid_dp
  import refid_pkg::*;
#(
  parameter int MAX_IDS    = MAX_IDS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  req_t             req,
  input  cmd_t             cmd,
  output stat_t            stat,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  output logic [CFG_W-1:0] first_fresh_id,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output rsp_t             rsp
);

  localparam int IW    = $clog2(MAX_IDS);
  localparam int QW    = $clog2(MAX_IDS + 1);
  localparam int FW    = (QW > CFG_W) ? QW : CFG_W;
  localparam int CW    = COUNT_BITS;
  localparam int RNGW  = TID_W + 1;
  localparam logic [RNGW-1:0] MAX_V   = RNGW'(MAX_IDS);
  localparam logic [FW-1:0]   MAX_F   = FW'(MAX_IDS);
  localparam logic [QW-1:0]   MAX_Q   = QW'(MAX_IDS);
  localparam logic [IW-1:0]   LAST_ID = IW'(MAX_IDS - 1);
  localparam logic [CW-1:0]   CNT_MAX = '1;
  localparam logic [CW-1:0]   CNT_ONE = CW'(1);

  req_t            req_q;
  logic [FW-1:0]   fresh_next;
  logic [FW-1:0]   fresh_base;
  logic            fresh_taken;
  logic [IW-1:0]   free_head;
  logic [IW-1:0]   free_tail;
  logic [QW-1:0]   free_count;

  logic [CW-1:0]   cnt_rdata;
  logic [IW-1:0]   fl_rdata;
  logic            cnt_we;
  logic [IW-1:0]   cnt_waddr;
  logic [CW-1:0]   cnt_wdata;

  logic            tid_in_range;
  logic [IW-1:0]   tid_id;
  logic            live;
  logic [CW-1:0]   cur;
  logic            push;
  logic            pop;
  logic            take_fresh;
  rsp_t            rsp_next;

  // Reference count table
  refid_ram #(
    .WIDTH (CW),
    .DEPTH (MAX_IDS)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (cmd.accept),
    .raddr (IW'(req.target_id)),
    .rdata (cnt_rdata)
  );

  // Free list storage, read at the head on every transfer
  refid_ram #(
    .WIDTH (IW),
    .DEPTH (MAX_IDS)
  ) u_free_ram (
    .clk   (clk),
    .we    (push),
    .waddr (free_tail),
    .wdata (tid_id),
    .re    (cmd.accept),
    .raddr (free_head),
    .rdata (fl_rdata)
  );

  // Latch the request
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_q <= req;
    end
  end

  // Counts were only ever written inside the fresh range handed out so far;
  // everything else is forced to read as zero.
  always_comb begin
    tid_in_range = (RNGW'(req_q.target_id) < MAX_V);
    tid_id       = IW'(req_q.target_id);
    live         = fresh_taken && (FW'(tid_id) >= fresh_base) && (FW'(tid_id) < fresh_next);
    cur          = live ? cnt_rdata : '0;
  end

  // Decide the update and the response
  always_comb begin
    cnt_we     = 1'b0;
    cnt_waddr  = tid_id;
    cnt_wdata  = cur;
    push       = 1'b0;
    pop        = 1'b0;
    take_fresh = 1'b0;
    rsp_next           = '0;
    rsp_next.result_id = ID_W'(req_q.target_id);
    case (req_q.mode)
      MODE_ALLOC: begin
        rsp_next.result_id = '0;
        if (free_count != '0) begin
          pop       = 1'b1;
          cnt_waddr = fl_rdata;
        end else if (fresh_next < MAX_F) begin
          take_fresh = 1'b1;
          cnt_waddr  = IW'(fresh_next);
        end
        if (pop || take_fresh) begin
          cnt_we             = 1'b1;
          cnt_wdata          = CNT_ONE;
          rsp_next.result_id = ID_W'(cnt_waddr);
          rsp_next.status    = STAT_OK;
          rsp_next.new_count = NCNT_W'(CNT_ONE);
        end else begin
          rsp_next.status = STAT_EMPTY;
        end
      end
      MODE_ADD: begin
        if (!tid_in_range) begin
          rsp_next.status = STAT_RANGE;
        end else if ((cur == '0) || (cur == CNT_MAX)) begin
          rsp_next.status    = STAT_COUNT;
          rsp_next.new_count = NCNT_W'(cur);
        end else begin
          cnt_we             = 1'b1;
          cnt_wdata          = cur + CNT_ONE;
          rsp_next.status    = STAT_OK;
          rsp_next.new_count = NCNT_W'(cur + CNT_ONE);
        end
      end
      MODE_DROP: begin
        if (!tid_in_range) begin
          rsp_next.status = STAT_RANGE;
        end else if (cur == '0) begin
          rsp_next.status = STAT_COUNT;
        end else begin
          cnt_we             = 1'b1;
          cnt_wdata          = cur - CNT_ONE;
          rsp_next.status    = STAT_OK;
          rsp_next.new_count = NCNT_W'(cur - CNT_ONE);
          if (cur == CNT_ONE) begin
            rsp_next.released = 1'b1;
            push              = (free_count < MAX_Q);
          end
        end
      end
      default: begin
        rsp_next.status = STAT_RANGE;
      end
    endcase
    // Only the commit cycle touches the stores
    cnt_we     = cnt_we && cmd.commit;
    push       = push && cmd.commit;
    pop        = pop && cmd.commit;
    take_fresh = take_fresh && cmd.commit;
  end

  // Advance the free list pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      free_head  <= '0;
      free_tail  <= '0;
      free_count <= '0;
    end else begin
      if (pop) begin
        free_head  <= (free_head == LAST_ID) ? '0 : free_head + IW'(1);
        free_count <= free_count - QW'(1);
      end
      if (push) begin
        free_tail  <= (free_tail == LAST_ID) ? '0 : free_tail + IW'(1);
        free_count <= free_count + QW'(1);
      end
    end
  end

  // Fresh counter and configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      first_fresh_id <= '0;
      fresh_next     <= '0;
      fresh_base     <= '0;
      fresh_taken    <= 1'b0;
    end else begin
      if (cfg_we) begin
        first_fresh_id <= cfg_wdata;
        if (!fresh_taken) begin
          fresh_next <= FW'(cfg_wdata);
        end
      end
      if (take_fresh) begin
        fresh_next  <= fresh_next + FW'(1);
        fresh_taken <= 1'b1;
        if (!fresh_taken) begin
          fresh_base <= fresh_next;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.commit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp <= rsp_next;
    end
  end

  assign stat.out_free = !rsp_valid || rsp_ready;

endmodule

// ===== rtl/core/refcounted_id_allocator.sv =====
// Flow: an accepted request gets a registered read of the count memory, then its write-back
//   and response are committed once the output slot is free; a stalled response holds the
//   commit, and no new request is taken before the previous one has committed.
// Reset: synchronous, active high; the count table needs no clearing pass, since
//   counts outside the handed-out fresh range read as zero. Requests taken at once.
module refcounted_id_allocator
  import refid_pkg::*;
#(
  parameter int MAX_IDS    = MAX_IDS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  req_t              req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output rsp_t              rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  cmd_t             cmd;
  stat_t            stat;
  logic             cfg_we;
  logic [CFG_W-1:0] first_fresh_id;

  // Decode the register port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_FIRST_FRESH);
  assign prdata = (paddr[2] == REG_FIRST_FRESH) ? APB_DW'(first_fresh_id) : '0;

  refid_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  refid_dp #(
    .MAX_IDS    (MAX_IDS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .req            (req),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_we         (cfg_we),
    .cfg_wdata      (pwdata[CFG_W-1:0]),
    .first_fresh_id (first_fresh_id),
    .rsp_valid      (rsp_valid),
    .rsp_ready      (rsp_ready),
    .rsp            (rsp)
  );

  // A response only appears after a commit
  a_rsp_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(cmd.commit))
    else $error("response appeared without a commit");

  // Never overwrite a waiting response
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!rsp_valid || rsp_ready))
    else $error("commit over a pending response");

  // One request in flight at a time
  a_one_inflight: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("second request taken while one is in flight");

  // Only a successful drop releases an identifier
  a_release_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.released) |-> (rsp.status == STAT_OK && rsp.new_count == '0))
    else $error("release flagged on a failed or nonzero result");

endmodule
